### hw/rtl/ppg_pkg.sv
// ----------------------------------------------------------------------------
// ppg_pkg
// Shared types, widths and constants for the plasma pixel generator.
// ----------------------------------------------------------------------------
package ppg_pkg;

    localparam int X_BITS       = 9;
    localparam int Y_BITS       = 8;
    localparam int CORDIC_STEPS = 16;

    localparam int LW_W   = 9;
    localparam int COL_W  = 8;
    localparam int ADDR_W = 17;

    localparam logic [LW_W-1:0] LINE_WIDTH_RESET = LW_W'(320);

    // product widths: a = x*x*y, b = y*y*x
    localparam int NA_W = 2 * X_BITS + Y_BITS;
    localparam int NB_W = 2 * Y_BITS + X_BITS;
    localparam int N_W  = (NA_W > NB_W) ? NA_W : NB_W;

    // turns-per-count constant, split in two halves for the phase multiply
    localparam logic [63:0] PHASE_K   = 64'd2935890503282;
    localparam int          K_HALF_W  = 21;
    localparam logic [K_HALF_W-1:0] PHASE_K_LO = PHASE_K[K_HALF_W-1:0];
    localparam logic [K_HALF_W-1:0] PHASE_K_HI = PHASE_K[2*K_HALF_W-1:K_HALF_W];
    localparam int          PP_W      = N_W + K_HALF_W;

    // CORDIC datapath
    localparam int CW     = 18;
    localparam int ZW     = 34;
    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic signed [CW-1:0] CORDIC_X0 = CW'(19898);

    localparam int ATAN_N     = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_N);

    localparam logic [31:0] ATAN_TURNS [0:ATAN_N-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667344,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } lane_t;

endpackage

### hw/rtl/ppg_cordic_stage.sv
// ----------------------------------------------------------------------------
// ppg_cordic_stage
// One registered CORDIC rotation step for a single lane.
// ----------------------------------------------------------------------------
module ppg_cordic_stage (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ppg_pkg::STEP_W-1:0] step,
    input  ppg_pkg::lane_t             lane_in,
    output ppg_pkg::lane_t             lane_out
);
    import ppg_pkg::*;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] angle;
    lane_t                lane_reg;
    lane_t                lane_next;

    always_comb
    begin
        dx        = lane_in.cy >>> step;
        dy        = lane_in.cx >>> step;
        angle     = $signed({{(ZW-32){1'b0}}, ATAN_TURNS[ATAN_IDX_W'(step)]});
        lane_next = lane_in;
        // rotate towards zero residual angle
        if (!lane_in.z[ZW-1])
        begin
            lane_next.cx = lane_in.cx - dx;
            lane_next.cy = lane_in.cy + dy;
            lane_next.z  = lane_in.z - angle;
        end
        else
        begin
            lane_next.cx = lane_in.cx + dx;
            lane_next.cy = lane_in.cy - dy;
            lane_next.z  = lane_in.z + angle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

### hw/rtl/plasma_pixel_generator_top.sv
// ----------------------------------------------------------------------------
// plasma_pixel_generator_top
// Plasma colour index and frame buffer address for one pixel per clock.
// ----------------------------------------------------------------------------
// Each transfer on the slave side carries one pixel coordinate; the matching
// master-side transfer carries its palette index (1..255) and its address
// y*line_width + x wrapped to 17 bits. The pipeline takes one pixel every
// clock unless it is full and stalled; results leave in order. Its stages:
// coordinate squares and row offset, cubic products and address, split
// phase partial products, phase sum and quadrant fold, one per CORDIC step,
// and the colour sum. Every stage holds its own valid bit and fills bubbles,
// so a stalled output blocks intake only once the whole pipe is full.
// line_width resets to 320 and is always ready on its write channel; write it
// only while the pipe is empty.
// ----------------------------------------------------------------------------
module plasma_pixel_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,        // line_width
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // [8:0] pixel_x, [16:9] pixel_y, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata     // [7:0] color_index, [24:8] pixel_address
);
    import ppg_pkg::*;

    localparam int DEPTH  = 5 + CORDIC_STEPS;
    localparam int XX_W   = 2 * X_BITS;
    localparam int YY_W   = 2 * Y_BITS;
    localparam int YLW_W  = Y_BITS + LW_W;
    localparam int ASUM_A = (YLW_W > X_BITS) ? YLW_W : X_BITS;
    localparam int ASUM_W = ((ASUM_A > ADDR_W) ? ASUM_A : ADDR_W) + 1;
    localparam int U_W    = CW + 2;

    // configuration
    logic [LW_W-1:0] line_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            line_width_reg <= cfg_data;
        end
    end

    // valid bits and per-stage advance: a stage loads when empty or draining
    logic [1:DEPTH] valid_reg;
    logic [1:DEPTH] en;

    always_comb
    begin
        en[DEPTH] = !valid_reg[DEPTH] || m_axis_tready;
        for (int k = DEPTH - 1; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= DEPTH; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 1: squares and the row offset
    logic [X_BITS-1:0] pixel_x;
    logic [Y_BITS-1:0] pixel_y;
    logic [XX_W-1:0]   xx_reg;
    logic [YY_W-1:0]   yy_reg;
    logic [YLW_W-1:0]  ylw_reg;
    logic [X_BITS-1:0] x1_reg;
    logic [Y_BITS-1:0] y1_reg;

    assign pixel_x = s_axis_tdata[X_BITS-1:0];
    assign pixel_y = s_axis_tdata[X_BITS+Y_BITS-1:X_BITS];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            xx_reg  <= XX_W'(pixel_x) * XX_W'(pixel_x);
            yy_reg  <= YY_W'(pixel_y) * YY_W'(pixel_y);
            ylw_reg <= YLW_W'(pixel_y) * YLW_W'(line_width_reg);
            x1_reg  <= pixel_x;
            y1_reg  <= pixel_y;
        end
    end

    // stage 2: the two cubic products and the address
    logic [NA_W-1:0]   a_reg;
    logic [NB_W-1:0]   b_reg;
    logic [ADDR_W-1:0] addr2_reg;
    logic [ASUM_W-1:0] addr_sum;

    assign addr_sum = ASUM_W'(ylw_reg) + ASUM_W'(x1_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            a_reg     <= NA_W'(xx_reg) * NA_W'(y1_reg);
            b_reg     <= NB_W'(yy_reg) * NB_W'(x1_reg);
            addr2_reg <= addr_sum[ADDR_W-1:0];
        end
    end

    // stage 3: phase partial products against the split constant
    logic [PP_W-1:0]   pa_lo_reg, pa_hi_reg, pb_lo_reg, pb_hi_reg;
    logic [ADDR_W-1:0] addr3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            pa_lo_reg <= PP_W'(a_reg) * PP_W'(PHASE_K_LO);
            pa_hi_reg <= PP_W'(a_reg) * PP_W'(PHASE_K_HI);
            pb_lo_reg <= PP_W'(b_reg) * PP_W'(PHASE_K_LO);
            pb_hi_reg <= PP_W'(b_reg) * PP_W'(PHASE_K_HI);
            addr3_reg <= addr2_reg;
        end
    end

    // stage 4: phase in turns, fold the left half plane onto the right
    logic [63:0]  phase_a, phase_b;
    logic [31:0]  ta, tb, ta_q, tb_q;
    lane_t        lane_a [0:CORDIC_STEPS];
    lane_t        lane_b [0:CORDIC_STEPS];
    lane_t        start_a_next, start_b_next;
    logic [ADDR_W-1:0] addr_pipe [0:CORDIC_STEPS];

    always_comb
    begin
        phase_a = (64'(pa_hi_reg) << K_HALF_W) + 64'(pa_lo_reg);
        phase_b = (64'(pb_hi_reg) << K_HALF_W) + 64'(pb_lo_reg);
        ta      = phase_a[63:32];
        tb      = phase_b[63:32];
        ta_q    = ta + 32'h4000_0000;
        tb_q    = tb + 32'h4000_0000;

        start_a_next.flip = ta_q[31];
        start_a_next.cx   = CORDIC_X0;
        start_a_next.cy   = '0;
        start_a_next.z    = ZW'($signed({ta[31] ^ ta_q[31], ta[30:0]}));

        start_b_next.flip = tb_q[31];
        start_b_next.cx   = CORDIC_X0;
        start_b_next.cy   = '0;
        start_b_next.z    = ZW'($signed({tb[31] ^ tb_q[31], tb[30:0]}));
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            lane_a[0]    <= start_a_next;
            lane_b[0]    <= start_b_next;
            addr_pipe[0] <= addr3_reg;
        end
    end

    // CORDIC steps: one rotation per stage, cosine lane and sine lane
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        ppg_cordic_stage u_step_a (
            .clk      (clk),
            .en       (en[5+g]),
            .step     (STEP_W'(g)),
            .lane_in  (lane_a[g]),
            .lane_out (lane_a[g+1])
        );

        ppg_cordic_stage u_step_b (
            .clk      (clk),
            .en       (en[5+g]),
            .step     (STEP_W'(g)),
            .lane_in  (lane_b[g]),
            .lane_out (lane_b[g+1])
        );

        always_ff @(posedge clk)
        begin
            if (en[5+g])
            begin
                addr_pipe[g+1] <= addr_pipe[g];
            end
        end
    end

    // final stage: undo the fold, sum, truncate toward zero, wrap
    logic signed [CW-1:0]  cos_v, sin_v;
    logic signed [U_W-1:0] sum_u, neg_u;
    logic [U_W-1:0]        whole;
    logic [COL_W-1:0]      color_next;
    logic [COL_W-1:0]      color_reg;
    logic [ADDR_W-1:0]     addr_out_reg;

    always_comb
    begin
        cos_v = lane_a[CORDIC_STEPS].flip ? -lane_a[CORDIC_STEPS].cx
                                          :  lane_a[CORDIC_STEPS].cx;
        sin_v = lane_b[CORDIC_STEPS].flip ? -lane_b[CORDIC_STEPS].cy
                                          :  lane_b[CORDIC_STEPS].cy;
        sum_u = U_W'(cos_v) + U_W'(sin_v) + U_W'(32768);
        neg_u = -sum_u;
        if (sum_u[U_W-1])
        begin
            whole = -(U_W'(neg_u) >> 8);
        end
        else
        begin
            whole = U_W'(sum_u) >> 8;
        end
        color_next = whole[COL_W-1:0];
        if (color_next == '0)
        begin
            color_next = '1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DEPTH])
        begin
            color_reg    <= color_next;
            addr_out_reg <= addr_pipe[CORDIC_STEPS];
        end
    end

    assign m_axis_tvalid = valid_reg[DEPTH];
    assign m_axis_tdata  = {7'd0, addr_out_reg, color_reg};

endmodule

### hw/rtl/ppg_checker.sv
// ----------------------------------------------------------------------------
// ppg_checker
// Port-level checks for the plasma pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
module ppg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // an empty output stage means the pipe can take a pixel
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("intake blocked with empty output");

    // colour index never zero
    a_color_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] != 8'd0)
        else $error("zero colour index");

    // configuration channel always takes a write
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind plasma_pixel_generator_top ppg_checker u_ppg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### dv/plasma_pixel_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plasma_pixel_generator_top_tb
// Self-checking bench for the plasma pixel generator.
// ----------------------------------------------------------------------------
// Drive pixel coordinates into the slave side, predict colour index and
// address in the bench, and compare every master-side transfer in order.
// Runs directed corners, then random pixels under several line widths with
// random gaps on both sides, then a closing stretch with no gaps.
// ----------------------------------------------------------------------------
module plasma_pixel_generator_top_tb;
    import ppg_pkg::*;

    localparam int PIPE_LAT = 5 + CORDIC_STEPS;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [COL_W-1:0]  color_index;
    } pixel_out_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;     // [8:0] pixel_x, [16:9] pixel_y, rest zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [7:0] color_index, [24:8] pixel_address

    logic [LW_W-1:0] cur_line_width;
    pixel_out_t      pending_pixels[$];
    bit              failed;
    bit              gaps_on;

    plasma_pixel_generator_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Arithmetic shift right with floor, on 32-bit signed words.
    function automatic int shift_floor(int v, int s);
        return v >>> s;
    endfunction

    // Fixed-length CORDIC rotation for angle n/1e6 rad; returns cos or sin in Q1.15.
    function automatic int plasma_trig(longint unsigned n, bit want_sin);
        longint unsigned phase;
        logic [31:0]     t;
        bit              flip;
        longint          z;
        int              cx;
        int              cy;
        int              dx;
        int              dy;
        phase = n * PHASE_K;
        t     = phase[63:32];
        flip  = (t + 32'h4000_0000) >> 31;
        cx    = 19898;
        cy    = 0;
        if (flip)
            t = t - 32'h8000_0000;
        z = longint'(t);
        if (t[31])
            z = z - 64'sd4294967296;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = shift_floor(cy, i);
            dy = shift_floor(cx, i);
            if (z >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - longint'(ATAN_TURNS[i]);
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + longint'(ATAN_TURNS[i]);
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        return want_sin ? cy : cx;
    endfunction

    function automatic pixel_out_t plasma_pixel(logic [8:0] px, logic [7:0] py);
        pixel_out_t      r;
        longint unsigned x;
        longint unsigned y;
        int              total;
        int              whole;
        x     = px;
        y     = py;
        total = (plasma_trig(x * x * y, 1'b0) + plasma_trig(y * y * x, 1'b1) + 32768) * 128;
        // truncate toward zero; negative values wrap through the low byte
        if (total >= 0)
            whole = total / 32768;
        else
            whole = -((-total) / 32768);
        r.color_index = whole[7:0];
        if (r.color_index == '0)
            r.color_index = 8'd255;
        r.pixel_address = ADDR_W'(y * cur_line_width + x);
        return r;
    endfunction

    // Drop tvalid for a random burst of idle cycles.
    task automatic idle_gap();
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    // Send one pixel and record its expected transfer once accepted; tvalid
    // stays high afterwards so the next pixel can follow with no gap.
    task automatic send_pixel(logic [8:0] px, logic [7:0] py);
        idle_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, py, px};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_pixels.push_back(plasma_pixel(px, py));
        @(negedge clk);
    endtask

    // Drain the pipe, let it settle, then write line_width.
    task automatic set_line_width(logic [8:0] lw);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 2) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lw;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_line_width = lw;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Compare each master-side transfer against the oldest expectation.
    always @(posedge clk)
    begin
        pixel_out_t got;
        pixel_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[24:0];
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected transfer %h", m_axis_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.color_index !== want.color_index)
                begin
                    $error("color_index: expected %0d, got %0d",
                           want.color_index, got.color_index);
                    failed = 1'b1;
                end
                if (got.pixel_address !== want.pixel_address)
                begin
                    $error("pixel_address: expected %0d, got %0d",
                           want.pixel_address, got.pixel_address);
                    failed = 1'b1;
                end
            end
        end
    end

    // Random back-pressure on the master side, in bursts.
    always
    begin
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    task automatic test_reset_width();
        send_pixel(9'd0, 8'd0);
        send_pixel(9'd511, 8'd255);
        send_pixel(9'd319, 8'd1);
    endtask

    task automatic test_corners();
        set_line_width(9'd511);
        send_pixel(9'd511, 8'd255);    // widest address, still fits in 17 bits
        send_pixel(9'd0, 8'd255);
        send_pixel(9'd511, 8'd0);
        send_pixel(9'h155, 8'haa);
        send_pixel(9'h0aa, 8'h55);
        set_line_width(9'd1);
        send_pixel(9'd1, 8'd1);
        send_pixel(9'd256, 8'd128);
        set_line_width(9'd0);          // zero width gives address = x
        send_pixel(9'd300, 8'd200);
        send_pixel(9'd17, 8'd99);
        // sweep for zero colour and negative sums
        for (int i = 0; i < 12; i++)
            send_pixel(9'(400 + i * 9), 8'(180 + i * 6));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_pixel(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_width_sweep();
        logic [8:0] widths[5] = '{9'd511, 9'd1, 9'd320, 9'd0, 9'd257};
        foreach (widths[k])
        begin
            set_line_width(k == 4 ? 9'($urandom_range(1, 511)) : widths[k]);
            test_random(150);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b1;
        failed         = 1'b0;
        gaps_on        = 1'b1;
        cur_line_width = LINE_WIDTH_RESET;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_width();
        test_corners();
        test_width_sweep();
        gaps_on = 1'b0;
        test_random(80);
        s_axis_tvalid <= 1'b0;

        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 4) @(negedge clk);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### plasma_pixel_generator_top.f
hw/rtl/ppg_pkg.sv
hw/rtl/ppg_cordic_stage.sv
hw/rtl/plasma_pixel_generator_top.sv
hw/rtl/ppg_checker.sv
dv/plasma_pixel_generator_top_tb.sv
